@@ rtl/tpp_pkg.sv @@
// Shared types and constants of the touch point predictor.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tpp_pkg;

    // Fraction bits of all time values.
    localparam int FRAC_BITS = 20;

    localparam int COORD_W = 16;
    localparam int TIME_W  = 48;
    localparam int DT_W    = TIME_W + 1;
    // Look-ahead time t = dt + extra; |dt| is bounded by the pause threshold.
    localparam int T_W     = 27;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MUL_W   = 28;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int N_W     = PROD_W + 1;

    localparam int THR_W   = 25;
    localparam int RATE_W  = 10;
    localparam int EXTRA_W = 21;
    localparam int CFG_W   = THR_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(104858);
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(60);
    localparam logic [EXTRA_W-1:0] EXTRA_RESET = EXTRA_W'(20972);

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA = 2'd2;

    // Request kinds carried in tuser.
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    // Stored velocity sign codes.
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    // One half in the fixed-point scale of the accumulator.
    localparam logic [N_W:0] ROUND_HALF = (N_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [N_W:0] SAT_MAG    = (N_W + 1)'(32768);
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;

    // What the rounding stage needs to know about one axis.
    typedef struct packed {
        logic signed [COORD_W-1:0] last_p;
        logic [1:0]                last_sign;
        logic                      v_neg;
        logic                      v_zero;
    } axis_ctl_t;

endpackage

`default_nettype wire

@@ rtl/touch_point_predictor.sv @@
// Touch point predictor top level: handshakes, sequencer and state registers.
// Depends on tpp_pkg, tpp_mul and tpp_round.
//
// The block takes one request on the s_ channel and returns at most one
// predicted point on the m_ channel. A request with tuser set to clear wipes
// the stored point and velocity signs and gives no result; the block stays
// ready for the next request. A predict request first forms the time gap and
// checks it against the pause threshold. When the gap is too large the
// stored point is repeated with held set, and the sequencer goes from the
// check state straight to the done state. Otherwise one shared multiplier
// computes both velocities and both extrapolated offsets in four passes, one
// rounding unit finishes the axes one after the other, and the result goes
// to the output register from the done state. s_tready is high only while
// the sequencer is idle, so a new request waits until the last predict is
// through its four multiplier passes, two rounding passes and the done state.
// A finished result waits in the output register while m_tready is low; the
// block accepts the next request meanwhile but holds the next result until
// the register is free. Reset restores the register defaults and clears the
// stored point and signs. Configuration writes are always accepted.
`default_nettype none

module touch_point_predictor
    import tpp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // newest_x, newest_y, prior_x, prior_y, newest_time, now_time
    input  wire logic [159:0]          s_tdata,
    // req_type
    input  wire logic [0:0]            s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_x, out_y
    output logic [31:0]                m_tdata,
    // held
    output logic [0:0]                 m_tuser,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_MVX  = 4'd2;
    localparam logic [3:0] S_MVY  = 4'd3;
    localparam logic [3:0] S_MTX  = 4'd4;
    localparam logic [3:0] S_MTY  = 4'd5;
    localparam logic [3:0] S_RX   = 4'd6;
    localparam logic [3:0] S_RY   = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [THR_W-1:0]   thr_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [EXTRA_W-1:0] extra_reg;

    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [DT_W-1:0]    dt_reg;
    logic signed [T_W-1:0]     t_reg;
    logic                      held_reg;
    logic signed [MUL_W-1:0]   vx_reg, vy_reg;
    logic signed [N_W-1:0]     n_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;

    logic signed [COORD_W-1:0] last_px_reg, last_py_reg;
    logic [1:0]                last_vx_sign_reg, last_vy_sign_reg;

    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                      out_held_reg;
    logic                      out_valid_reg;

    logic                      in_acc;
    logic                      out_load;
    logic [DT_W-1:0]           dt_in;
    logic [DT_W-1:0]           adt;
    logic                      held_now;
    logic signed [T_W-1:0]     t_next;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic                      mul_en;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [N_W-1:0]     n_next;
    axis_ctl_t                 rnd_ctl;
    logic signed [COORD_W-1:0] rnd_p;
    logic signed [COORD_W-1:0] fin_x, fin_y;
    logic [1:0]                code_x, code_y;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    assign dt_in    = {1'b0, s_tdata[159:112]} - {1'b0, s_tdata[111:64]};
    assign adt      = dt_reg[DT_W-1] ? DT_W'(-dt_reg) : DT_W'(dt_reg);
    assign held_now = adt > DT_W'(thr_reg);
    // Only used when the gap is within the threshold, where it fits T_W bits.
    assign t_next   = dt_reg[T_W-1:0] + T_W'(extra_reg);

    assign dx = DIFF_W'(x1_reg) - DIFF_W'(x2_reg);
    assign dy = DIFF_W'(y1_reg) - DIFF_W'(y2_reg);

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(dx);
        mul_b  = MUL_W'(rate_reg);
        unique case (state_reg)
            S_MVX:
            begin
                mul_a = MUL_W'(dx);
                mul_b = MUL_W'(rate_reg);
            end
            S_MVY:
            begin
                mul_a = MUL_W'(dy);
                mul_b = MUL_W'(rate_reg);
            end
            S_MTX:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = vx_reg;
            end
            S_MTY:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = vy_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    tpp_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // In S_MTY the product is the x offset, in S_RX the y offset.
    assign n_next = ((state_reg == S_MTY) ? (N_W'(x1_reg) <<< FRAC_BITS)
                                          : (N_W'(y1_reg) <<< FRAC_BITS))
                  + N_W'(prod);

    always_comb
    begin
        if (state_reg == S_RY)
        begin
            rnd_ctl.last_p    = last_py_reg;
            rnd_ctl.last_sign = last_vy_sign_reg;
            rnd_ctl.v_neg     = vy_reg[MUL_W-1];
            rnd_ctl.v_zero    = (vy_reg == '0);
        end
        else
        begin
            rnd_ctl.last_p    = last_px_reg;
            rnd_ctl.last_sign = last_vx_sign_reg;
            rnd_ctl.v_neg     = vx_reg[MUL_W-1];
            rnd_ctl.v_zero    = (vx_reg == '0);
        end
    end

    tpp_round u_round (
        .n   (n_reg),
        .ctl (rnd_ctl),
        .p   (rnd_p)
    );

    assign fin_x  = held_reg ? last_px_reg : px_reg;
    assign fin_y  = held_reg ? last_py_reg : py_reg;
    assign code_x = (held_reg || vx_reg == '0) ? SIGN_NONE
                  : (vx_reg[MUL_W-1] ? SIGN_NEG : SIGN_POS);
    assign code_y = (held_reg || vy_reg == '0) ? SIGN_NONE
                  : (vy_reg[MUL_W-1] ? SIGN_NEG : SIGN_POS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_tuser[0] == REQ_PREDICT))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:  state_next = held_now ? S_DONE : S_MVX;
            S_MVX:  state_next = S_MVY;
            S_MVY:  state_next = S_MTX;
            S_MTX:  state_next = S_MTY;
            S_MTY:  state_next = S_RX;
            S_RX:   state_next = S_RY;
            S_RY:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and the stored point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            thr_reg          <= THR_RESET;
            rate_reg         <= RATE_RESET;
            extra_reg        <= EXTRA_RESET;
            last_px_reg      <= '0;
            last_py_reg      <= '0;
            last_vx_sign_reg <= SIGN_NONE;
            last_vy_sign_reg <= SIGN_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PAUSE: thr_reg   <= cfg_data[THR_W-1:0];
                    CFG_RATE:  rate_reg  <= cfg_data[RATE_W-1:0];
                    CFG_EXTRA: extra_reg <= cfg_data[EXTRA_W-1:0];
                    default:   ;
                endcase
            end

            if (in_acc)
            begin
                if (s_tuser[0] == REQ_CLEAR)
                begin
                    last_px_reg      <= '0;
                    last_py_reg      <= '0;
                    last_vx_sign_reg <= SIGN_NONE;
                    last_vy_sign_reg <= SIGN_NONE;
                end
                else if (last_px_reg == '0 && last_py_reg == '0)
                begin
                    // An unset stored point takes the newest sample.
                    last_px_reg <= s_tdata[15:0];
                    last_py_reg <= s_tdata[31:16];
                end
            end
            else if (out_load)
            begin
                last_px_reg      <= fin_x;
                last_py_reg      <= fin_y;
                last_vx_sign_reg <= code_x;
                last_vy_sign_reg <= code_y;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x1_reg <= s_tdata[15:0];
            y1_reg <= s_tdata[31:16];
            x2_reg <= s_tdata[47:32];
            y2_reg <= s_tdata[63:48];
            dt_reg <= dt_in;
        end
        if (state_reg == S_CHK)
        begin
            held_reg <= held_now;
            t_reg    <= t_next;
            vx_reg   <= '0;
            vy_reg   <= '0;
        end
        if (state_reg == S_MVY)
        begin
            vx_reg <= prod[MUL_W-1:0];
        end
        if (state_reg == S_MTX)
        begin
            vy_reg <= prod[MUL_W-1:0];
        end
        if (state_reg == S_MTY || state_reg == S_RX)
        begin
            n_reg <= n_next;
        end
        if (state_reg == S_RX)
        begin
            px_reg <= rnd_p;
        end
        if (state_reg == S_RY)
        begin
            py_reg <= rnd_p;
        end
        if (out_load)
        begin
            out_x_reg    <= fin_x;
            out_y_reg    <= fin_y;
            out_held_reg <= held_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_y_reg, out_x_reg};
    assign m_tuser[0] = out_held_reg;

    a_clear_wipes_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser[0] == REQ_CLEAR) |=>
            (last_px_reg == '0 && last_py_reg == '0
             && last_vx_sign_reg == SIGN_NONE && last_vy_sign_reg == SIGN_NONE))
        else $error("clear request left stored state behind");

    a_held_clears_signs: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (!m_tuser[0]
                      || (last_vx_sign_reg == SIGN_NONE && last_vy_sign_reg == SIGN_NONE)))
        else $error("held result kept a velocity sign");

    a_result_is_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && m_tdata == {last_py_reg, last_px_reg}))
        else $error("delivered point differs from stored point");

    a_sign_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (last_vx_sign_reg == SIGN_NONE || last_vx_sign_reg == SIGN_POS
         || last_vx_sign_reg == SIGN_NEG)
        && (last_vy_sign_reg == SIGN_NONE || last_vy_sign_reg == SIGN_POS
         || last_vy_sign_reg == SIGN_NEG))
        else $error("unused velocity sign code stored");

endmodule

`default_nettype wire

@@ rtl/tpp_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on tpp_pkg for operand and product widths.
`default_nettype none

module tpp_mul
    import tpp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/tpp_round.sv @@
// Rounding, saturation and direction hold for one axis of the prediction.
// Depends on tpp_pkg for widths, sign codes and the axis control struct.
`default_nettype none

module tpp_round
    import tpp_pkg::*;
(
    input  wire logic signed [N_W-1:0]     n,
    input  wire axis_ctl_t                 ctl,
    output logic signed [COORD_W-1:0]      p
);

    logic                      neg;
    logic [N_W-1:0]            mag;
    logic [N_W:0]              sum;
    logic [N_W:0]              q_full;
    logic [COORD_W:0]          qs;
    logic [COORD_W:0]          qs_neg;
    logic signed [COORD_W-1:0] p_sat;
    logic                      opposite;
    logic                      keep;

    assign neg    = n[N_W-1];
    assign mag    = neg ? N_W'(-n) : N_W'(n);
    // Adding one half to the magnitude rounds half away from zero.
    assign sum    = {1'b0, mag} + ROUND_HALF;
    assign q_full = sum >> FRAC_BITS;
    assign qs     = (q_full > SAT_MAG) ? SAT_MAG[COORD_W:0] : q_full[COORD_W:0];
    assign qs_neg = (COORD_W + 1)'(0) - qs;

    always_comb
    begin
        if (neg)
        begin
            p_sat = qs_neg[COORD_W-1:0];
        end
        else if (qs > (COORD_W + 1)'(COORD_MAX))
        begin
            p_sat = COORD_MAX;
        end
        else
        begin
            p_sat = qs[COORD_W-1:0];
        end
    end

    // The point may only step back when the motion reversed its direction.
    assign opposite = ((ctl.last_sign == SIGN_POS) && ctl.v_neg)
                   || ((ctl.last_sign == SIGN_NEG) && !ctl.v_neg && !ctl.v_zero);
    assign keep = !opposite
               && (ctl.v_zero
                   || (ctl.v_neg && (p_sat > ctl.last_p))
                   || (!ctl.v_neg && (p_sat < ctl.last_p)));

    assign p = keep ? ctl.last_p : p_sat;

endmodule

`default_nettype wire
